// ===== hw/rtl/tps_pkg.sv =====
// tps_pkg: shared constants, status and register codes, and the root table
// for the top-p token sampler. No dependencies.
package tps_pkg;

    localparam int VOCAB_MAX_DEF = 4096;
    localparam int LOGIT_BITS    = 16;
    localparam int WEIGHT_BITS   = 24;
    localparam int TEMP_BITS     = 16;
    localparam int TOPP_BITS     = 17;
    localparam int TOKEN_BITS    = 12;
    localparam int STAT_BITS     = 2;

    localparam logic [TEMP_BITS-1:0] TEMP_RESET = 16'd256;
    localparam logic [TOPP_BITS-1:0] TOPP_RESET = 17'h10000;
    localparam logic [TOPP_BITS-1:0] TOPP_ONE   = 17'h10000;

    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [30:0] ONE_Q30   = 31'h40000000;

    localparam logic [STAT_BITS-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_BAD_TOPP = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic REG_TEMP = 1'b0;
    localparam logic REG_TOPP = 1'b1;

    typedef logic [31:0] root_tab_t [17];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] bit_v;
        n     = n_in;
        r     = 64'd0;
        bit_v = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (n >= r + bit_v)
            begin
                n = n - (r + bit_v);
                r = (r >> 1) + bit_v;
            end
            else
            begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    // R[k] ~ 2^(-2^-k) in Q1.30
    function automatic root_tab_t build_roots();
        root_tab_t t;
        logic [63:0] r;
        t[0] = 32'h20000000;
        r    = isqrt64(64'd1 << 59);
        t[1] = r[31:0];
        for (int k = 2; k < 17; k++)
        begin
            r    = isqrt64(r << 30);
            t[k] = r[31:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOTS = build_roots();

endpackage

// ===== hw/rtl/tps_weight.sv =====
// tps_weight: one weight exp((-d)/temperature) in Q1.23 per start pulse.
// Bit-serial divider, then one shared 32x32 multiplier. Uses tps_pkg.
module tps_weight
    import tps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [LOGIT_BITS-1:0]  diff,
    input  logic [TEMP_BITS-1:0]   temp,
    output logic                   done,
    output logic [WEIGHT_BITS-1:0] weight
);

    typedef enum logic [4:0] {
        WU_IDLE  = 5'b00001,
        WU_DIV   = 5'b00010,
        WU_MULY  = 5'b00100,
        WU_EXP   = 5'b01000,
        WU_SHIFT = 5'b10000
    } wu_state_t;

    wu_state_t state_reg, state_next;
    logic                   done_reg, done_next;
    logic [4:0]             step_reg, step_next;
    logic [TEMP_BITS-1:0]   temp_reg, temp_next;
    logic [15:0]            rem_reg, rem_next;
    logic [31:0]            quo_reg, quo_next;
    logic [32:0]            y_reg, y_next;
    logic [30:0]            m_reg, m_next;
    logic [WEIGHT_BITS-1:0] weight_reg, weight_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [16:0] trial;
    logic        ge;
    logic [3:0]  bsel;
    logic [4:0]  ridx;
    logic [16:0] ipart;
    logic [5:0]  shamt;
    logic [63:0] rsum;
    logic [63:0] rnd;

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = trial >= {1'b0, temp_reg};
    assign bsel  = step_reg[3:0];
    assign ridx  = 5'd16 - {1'b0, bsel};
    assign ipart = y_reg[32:16];
    assign shamt = 6'd30 + ipart[5:0];
    assign rsum  = (64'(m_reg) << (WEIGHT_BITS - 1)) + (64'd1 << (shamt - 6'd1));
    assign rnd   = mul_p + (64'd1 << 29);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        temp_next   = temp_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        y_next      = y_reg;
        m_next      = m_reg;
        weight_next = weight_reg;
        mul_a       = quo_reg;
        mul_b       = LOG2E_Q30;
        unique case (state_reg)
            WU_IDLE:
            begin
                if (start)
                begin
                    temp_next  = temp;
                    rem_next   = 16'd0;
                    quo_next   = {diff, 16'd0};
                    step_next  = 5'd31;
                    state_next = WU_DIV;
                end
            end
            WU_DIV:
            begin
                rem_next = ge ? 16'(trial - {1'b0, temp_reg}) : trial[15:0];
                quo_next = {quo_reg[30:0], ge};
                if (step_reg == 5'd0)
                    state_next = WU_MULY;
                else
                    step_next = step_reg - 5'd1;
            end
            WU_MULY:
            begin
                y_next     = mul_p[62:30];
                m_next     = ONE_Q30;
                step_next  = 5'd15;
                state_next = WU_EXP;
            end
            WU_EXP:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = ROOTS[ridx];
                if (y_reg[bsel])
                    m_next = rnd[60:30];
                if (step_reg == 5'd0)
                    state_next = WU_SHIFT;
                else
                    step_next = step_reg - 5'd1;
            end
            WU_SHIFT:
            begin
                if (ipart >= 17'd33)
                    weight_next = '0;
                else
                    weight_next = WEIGHT_BITS'(rsum >> shamt);
                done_next  = 1'b1;
                state_next = WU_IDLE;
            end
            default:
            begin
                state_next = WU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        temp_reg   <= temp_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        y_reg      <= y_next;
        m_reg      <= m_next;
        weight_reg <= weight_next;
    end

    assign done   = done_reg;
    assign weight = weight_reg;

endmodule

// ===== hw/rtl/top_p_token_sampler.sv =====
// top_p_token_sampler: loads a logit vector, one beat per cycle while s_tready is high, and
// returns one token after the last beat. Uses tps_pkg and tps_weight.
// After the last beat: greedy scans the logits for the maximum; sampling computes weights (serial
// divider and exp loop in tps_weight), then runs ceil(log2 n) merge passes through the order
// memory, then the nucleus and draw scans.
// Reset clears control, count, max and config; memories keep contents, no clear pass.
module top_p_token_sampler
    import tps_pkg::*;
#(
    parameter int VOCAB_MAX = VOCAB_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] logit_value, [47:16] draw_fraction
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] token_index, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(VOCAB_MAX);
    localparam int CNT_W = IDX_W + 1;
    localparam int POS_W = CNT_W + 1;
    localparam int SUM_W = IDX_W + WEIGHT_BITS;
    localparam int ENT_W = WEIGHT_BITS + IDX_W;
    localparam int ADR_W = IDX_W + 1;
    localparam int DEPTH = 2 ** IDX_W;

    typedef enum logic [18:0] {
        ST_LOAD   = 19'h00001,
        ST_GR_RD  = 19'h00002,
        ST_GR_CHK = 19'h00004,
        ST_W_RD   = 19'h00008,
        ST_W_GO   = 19'h00010,
        ST_W_WAIT = 19'h00020,
        ST_T_LO   = 19'h00040,
        ST_T_HI   = 19'h00080,
        ST_M_SET  = 19'h00100,
        ST_M_RA   = 19'h00200,
        ST_M_RB   = 19'h00400,
        ST_M_WR   = 19'h00800,
        ST_N_RD   = 19'h01000,
        ST_N_ACC  = 19'h02000,
        ST_D_LO   = 19'h04000,
        ST_D_HI   = 19'h08000,
        ST_S_RD   = 19'h10000,
        ST_S_ACC  = 19'h20000,
        ST_OUT    = 19'h40000
    } state_t;

    localparam logic signed [LOGIT_BITS-1:0] LOGIT_MIN = {1'b1, {(LOGIT_BITS-1){1'b0}}};

    // memories
    logic [LOGIT_BITS-1:0] logit_mem [DEPTH];
    logic [ENT_W-1:0]      ord_mem [2*DEPTH];

    state_t state_reg, state_next;
    logic [TEMP_BITS-1:0]         temp_reg, temp_next;
    logic [TOPP_BITS-1:0]         topp_reg, topp_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic signed [LOGIT_BITS-1:0] max_reg, max_next;
    logic                         out_vld_reg, out_vld_next;

    logic [31:0]            draw_reg, draw_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       ncnt_reg, ncnt_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic [SUM_W-1:0]       nuc_reg, nuc_next;
    logic [SUM_W-1:0]       cum_reg, cum_next;
    logic [63:0]            thr_reg, thr_next;
    logic [63:0]            prod_reg, prod_next;
    logic [63:0]            target_reg, target_next;
    logic [POS_W-1:0]       width_reg, width_next;
    logic [POS_W-1:0]       lo_reg, lo_next;
    logic [POS_W-1:0]       mid_reg, mid_next;
    logic [POS_W-1:0]       hi_reg, hi_next;
    logic [POS_W-1:0]       a_reg, a_next;
    logic [POS_W-1:0]       b_reg, b_next;
    logic [POS_W-1:0]       k_reg, k_next;
    logic                   bank_reg, bank_next;
    logic [ENT_W-1:0]       ha_reg, ha_next;
    logic [TOKEN_BITS-1:0]  res_tok_reg, res_tok_next;
    logic [STAT_BITS-1:0]   res_stat_reg, res_stat_next;
    logic [TOKEN_BITS-1:0]  out_tok_reg, out_tok_next;
    logic [STAT_BITS-1:0]   out_stat_reg, out_stat_next;
    logic [LOGIT_BITS-1:0]  logit_rd_reg;
    logic [ENT_W-1:0]       ord_rd_reg;

    logic                         acc_in;
    logic                         full;
    logic signed [LOGIT_BITS-1:0] logit_in;
    logic                         lg_wr;
    logic [IDX_W-1:0]             lg_raddr;
    logic                         ord_wr;
    logic [ADR_W-1:0]             ord_waddr;
    logic [ENT_W-1:0]             ord_wdata;
    logic [ADR_W-1:0]             ord_raddr;
    logic [31:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [63:0]                  mul_p;
    logic                         cfg_wr;
    logic                         wu_start;
    logic                         wu_done;
    logic [WEIGHT_BITS-1:0]       wu_weight;
    logic [LOGIT_BITS:0]          diff_full;
    logic [WEIGHT_BITS-1:0]       rd_w;
    logic [IDX_W-1:0]             rd_idx;
    logic [WEIGHT_BITS-1:0]       ha_w;
    logic [IDX_W-1:0]             ha_idx;
    logic                         b_first;
    logic                         take_b;
    logic [POS_W-1:0]             n_pos;
    logic [POS_W-1:0]             lo_w;
    logic [POS_W-1:0]             lo_2w;
    logic [POS_W-1:0]             k_inc;
    logic [SUM_W-1:0]             nuc_sum;
    logic [SUM_W-1:0]             cum_sum;
    logic [63:0]                  tot64;
    logic [63:0]                  nuc64;
    logic [CNT_W-1:0]             idx_inc;

    assign acc_in    = s_tvalid && s_tready;
    assign full      = count_reg == CNT_W'(VOCAB_MAX);
    assign logit_in  = s_tdata[LOGIT_BITS-1:0];
    assign cfg_wr    = psel && penable && pwrite;
    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign diff_full = {max_reg[LOGIT_BITS-1], max_reg}
                     - {logit_rd_reg[LOGIT_BITS-1], logit_rd_reg};
    assign rd_w      = ord_rd_reg[ENT_W-1:IDX_W];
    assign rd_idx    = ord_rd_reg[IDX_W-1:0];
    assign ha_w      = ha_reg[ENT_W-1:IDX_W];
    assign ha_idx    = ha_reg[IDX_W-1:0];
    assign b_first   = (rd_w > ha_w) || ((rd_w == ha_w) && (rd_idx < ha_idx));
    assign take_b    = (b_reg < hi_reg) && ((a_reg >= mid_reg) || b_first);
    assign n_pos     = POS_W'(count_reg);
    assign lo_w      = lo_reg + width_reg;
    assign lo_2w     = lo_reg + (width_reg << 1);
    assign k_inc     = k_reg + POS_W'(1);
    assign nuc_sum   = nuc_reg + SUM_W'(rd_w);
    assign cum_sum   = cum_reg + SUM_W'(rd_w);
    assign tot64     = 64'(total_reg);
    assign nuc64     = 64'(nuc_reg);
    assign idx_inc   = idx_reg + CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        temp_next     = temp_reg;
        topp_next     = topp_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        max_next      = max_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        draw_next     = draw_reg;
        idx_next      = idx_reg;
        ncnt_next     = ncnt_reg;
        total_next    = total_reg;
        nuc_next      = nuc_reg;
        cum_next      = cum_reg;
        thr_next      = thr_reg;
        prod_next     = prod_reg;
        target_next   = target_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        bank_next     = bank_reg;
        ha_next       = ha_reg;
        res_tok_next  = res_tok_reg;
        res_stat_next = res_stat_reg;
        out_tok_next  = out_tok_reg;
        out_stat_next = out_stat_reg;
        lg_wr         = 1'b0;
        lg_raddr      = idx_reg[IDX_W-1:0];
        ord_wr        = 1'b0;
        ord_waddr     = {1'b0, idx_reg[IDX_W-1:0]};
        ord_wdata     = {wu_weight, idx_reg[IDX_W-1:0]};
        ord_raddr     = {bank_reg, idx_reg[IDX_W-1:0]};
        mul_a         = draw_reg;
        mul_b         = nuc64[31:0];
        wu_start      = 1'b0;

        if (cfg_wr)
        begin
            if (paddr[2] == REG_TEMP)
                temp_next = pwdata[TEMP_BITS-1:0];
            else
                topp_next = pwdata[TOPP_BITS-1:0];
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc_in)
                begin
                    if (!full)
                    begin
                        lg_wr      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (logit_in > max_reg)
                            max_next = logit_in;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        draw_next    = s_tdata[47:16];
                        idx_next     = '0;
                        total_next   = '0;
                        res_tok_next = '0;
                        if (ovf_reg || full)
                        begin
                            res_stat_next = STAT_OVERFLOW;
                            state_next    = ST_OUT;
                        end
                        else if (temp_reg == '0)
                        begin
                            state_next = ST_GR_RD;
                        end
                        else if (topp_reg == '0 || topp_reg > TOPP_ONE)
                        begin
                            res_stat_next = STAT_BAD_TOPP;
                            state_next    = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_W_RD;
                        end
                    end
                end
            end
            ST_GR_RD:
            begin
                state_next = ST_GR_CHK;
            end
            ST_GR_CHK:
            begin
                res_stat_next = STAT_OK;
                if ($signed(logit_rd_reg) == max_reg)
                begin
                    res_tok_next = TOKEN_BITS'(idx_reg);
                    state_next   = ST_OUT;
                end
                else if (idx_inc == count_reg)
                begin
                    res_tok_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_GR_RD;
                end
            end
            ST_W_RD:
            begin
                state_next = ST_W_GO;
            end
            ST_W_GO:
            begin
                wu_start   = 1'b1;
                state_next = ST_W_WAIT;
            end
            ST_W_WAIT:
            begin
                if (wu_done)
                begin
                    ord_wr     = 1'b1;
                    total_next = total_reg + SUM_W'(wu_weight);
                    if (idx_inc == count_reg)
                    begin
                        state_next = ST_T_LO;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = ST_W_RD;
                    end
                end
            end
            ST_T_LO:
            begin
                mul_a      = 32'(topp_reg);
                mul_b      = tot64[31:0];
                thr_next   = mul_p;
                state_next = ST_T_HI;
            end
            ST_T_HI:
            begin
                mul_a      = 32'(topp_reg);
                mul_b      = tot64[63:32];
                thr_next   = thr_reg + (mul_p << 32);
                bank_next  = 1'b0;
                idx_next   = '0;
                nuc_next   = '0;
                width_next = POS_W'(1);
                lo_next    = '0;
                if (count_reg == CNT_W'(1))
                    state_next = ST_N_RD;
                else
                    state_next = ST_M_SET;
            end
            ST_M_SET:
            begin
                mid_next   = (lo_w > n_pos) ? n_pos : lo_w;
                hi_next    = (lo_2w > n_pos) ? n_pos : lo_2w;
                a_next     = lo_reg;
                b_next     = (lo_w > n_pos) ? n_pos : lo_w;
                k_next     = lo_reg;
                state_next = ST_M_RA;
            end
            ST_M_RA:
            begin
                ord_raddr  = {bank_reg, a_reg[IDX_W-1:0]};
                state_next = ST_M_RB;
            end
            ST_M_RB:
            begin
                ha_next    = ord_rd_reg;
                ord_raddr  = {bank_reg, b_reg[IDX_W-1:0]};
                state_next = ST_M_WR;
            end
            ST_M_WR:
            begin
                ord_wr    = 1'b1;
                ord_waddr = {!bank_reg, k_reg[IDX_W-1:0]};
                ord_wdata = take_b ? ord_rd_reg : ha_reg;
                if (take_b)
                    b_next = b_reg + POS_W'(1);
                else
                    a_next = a_reg + POS_W'(1);
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (lo_2w >= n_pos)
                    begin
                        bank_next  = !bank_reg;
                        width_next = width_reg << 1;
                        lo_next    = '0;
                        if ((width_reg << 1) >= n_pos)
                        begin
                            idx_next   = '0;
                            nuc_next   = '0;
                            state_next = ST_N_RD;
                        end
                        else
                        begin
                            state_next = ST_M_SET;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_2w;
                        state_next = ST_M_SET;
                    end
                end
                else
                begin
                    state_next = ST_M_RA;
                end
            end
            ST_N_RD:
            begin
                state_next = ST_N_ACC;
            end
            ST_N_ACC:
            begin
                nuc_next = nuc_sum;
                if (idx_inc != count_reg && ((64'(nuc_sum) << 16) < thr_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = ST_N_RD;
                end
                else
                begin
                    ncnt_next  = idx_inc;
                    state_next = ST_D_LO;
                end
            end
            ST_D_LO:
            begin
                prod_next  = mul_p;
                state_next = ST_D_HI;
            end
            ST_D_HI:
            begin
                mul_b       = nuc64[63:32];
                target_next = mul_p + {32'd0, prod_reg[63:32]};
                idx_next    = '0;
                cum_next    = '0;
                state_next  = ST_S_RD;
            end
            ST_S_RD:
            begin
                state_next = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                cum_next = cum_sum;
                if (target_reg <= 64'(cum_sum) || idx_inc == ncnt_reg)
                begin
                    res_tok_next  = TOKEN_BITS'(rd_idx);
                    res_stat_next = STAT_OK;
                    state_next    = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_S_RD;
                end
            end
            ST_OUT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_tok_next  = res_tok_reg;
                    out_stat_next = res_stat_reg;
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    max_next      = LOGIT_MIN;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            temp_reg    <= TEMP_RESET;
            topp_reg    <= TOPP_RESET;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            max_reg     <= LOGIT_MIN;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            temp_reg    <= temp_next;
            topp_reg    <= topp_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            max_reg     <= max_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg     <= draw_next;
        idx_reg      <= idx_next;
        ncnt_reg     <= ncnt_next;
        total_reg    <= total_next;
        nuc_reg      <= nuc_next;
        cum_reg      <= cum_next;
        thr_reg      <= thr_next;
        prod_reg     <= prod_next;
        target_reg   <= target_next;
        width_reg    <= width_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        bank_reg     <= bank_next;
        ha_reg       <= ha_next;
        res_tok_reg  <= res_tok_next;
        res_stat_reg <= res_stat_next;
        out_tok_reg  <= out_tok_next;
        out_stat_reg <= out_stat_next;
    end

    always_ff @(posedge clk)
    begin
        if (lg_wr)
            logit_mem[count_reg[IDX_W-1:0]] <= logit_in;
        logit_rd_reg <= logit_mem[lg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_wr)
            ord_mem[ord_waddr] <= ord_wdata;
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    tps_weight u_weight (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (wu_start),
        .diff   (diff_full[LOGIT_BITS-1:0]),
        .temp   (temp_reg),
        .done   (wu_done),
        .weight (wu_weight)
    );

    assign s_tready = state_reg == ST_LOAD;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = 16'(out_tok_reg);
    assign m_tuser  = out_stat_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_TEMP) ? 32'(temp_reg) : 32'(topp_reg);

    a_wu_done: assert property (@(posedge clk) disable iff (!rst_n)
        wu_done |-> state_reg == ST_W_WAIT)
        else $error("weight done outside weight wait");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VOCAB_MAX))
        else $error("item count beyond capacity");

    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_S_ACC |-> idx_reg < ncnt_reg)
        else $error("draw scan past nucleus");

    a_merge: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M_WR |-> (a_reg < mid_reg || b_reg < hi_reg))
        else $error("merge write with both runs empty");

endmodule

// ===== test/top_p_token_sampler_tb.sv =====
// Testbench for top_p_token_sampler: drives logit vectors over the stream port,
// programs temperature and top_p over APB, and checks each token and status.
// Depends on tps_pkg and the sampler RTL.
module top_p_token_sampler_tb;
    import tps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOCAB = 4096;
    localparam int STALL_LIMIT = 200000;
    localparam logic [63:0] LOG2E = 64'd1549082005;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [11:0] token;
        logic [1:0]  status;
    } pick_t;

    typedef struct {
        logic [15:0] logit;
        logic        last;
        logic [31:0] draw;
        logic [15:0] temp;
        logic [16:0] topp;
        logic        typed;
        pick_t       pick;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [15:0] logit_value, [47:16] draw_fraction
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [11:0] token_index, [15:12] zero
    logic [1:0]  m_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    top_p_token_sampler u_top (.*);

    pick_t       picks_due[$];
    logic signed [15:0] vec_logits[$];
    logic signed [15:0] vec_max;
    logic        vec_overflow;
    logic [15:0] cur_temp;
    logic [16:0] cur_topp;
    logic [63:0] roots[17];
    logic [63:0] wts[VOCAB];
    int          order[VOCAB];
    int          send_idle;
    int          recv_idle;
    int          errors;
    int          stall_cycles;
    row_t        rows[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] softmax_weight(input logic [63:0] d, input logic [15:0] t);
        logic [63:0] z;
        logic [63:0] y;
        logic [63:0] m;
        logic [63:0] s;
        z = (d << 16) / t;
        if (z >= (64'd1 << 32))
            return 0;
        y = (z * LOG2E) >> 30;
        m = Q30;
        for (int b = 15; b >= 0; b--)
            if (y[b])
                m = (m * roots[16-b] + (64'd1 << 29)) >> 30;
        s = 30 + (y >> 16);
        if (s >= 63)
            return 0;
        return ((m << (WEIGHT_BITS-1)) + (64'd1 << (s-1))) >> s;
    endfunction

    function automatic logic heavier(input int a, input int b);
        if (wts[a] != wts[b])
            return wts[a] > wts[b];
        return a < b;
    endfunction

    function automatic pick_t sample_token(input logic [31:0] draw);
        pick_t       p;
        int          n;
        int          cnt;
        int          key;
        int          j;
        logic [63:0] total;
        logic [63:0] nucleus;
        logic [63:0] cum;
        logic [95:0] target;
        p = '0;
        n = vec_logits.size();
        if (vec_overflow)
        begin
            p.status = STAT_OVERFLOW;
            return p;
        end
        if (cur_temp == 0)
        begin
            for (int i = 0; i < n; i++)
                if (vec_logits[i] == vec_max)
                begin
                    p.token = 12'(i);
                    return p;
                end
            return p;
        end
        if (cur_topp == 0 || cur_topp > TOPP_ONE)
        begin
            p.status = STAT_BAD_TOPP;
            return p;
        end
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            wts[i] = softmax_weight(64'(int'(vec_max) - int'(vec_logits[i])), cur_temp);
            total += wts[i];
            order[i] = i;
        end
        for (int i = 1; i < n; i++)
        begin
            key = order[i];
            j = i - 1;
            while (j >= 0 && heavier(key, order[j]))
            begin
                order[j+1] = order[j];
                j--;
            end
            order[j+1] = key;
        end
        nucleus = 0;
        cnt = 0;
        do
        begin
            nucleus += wts[order[cnt]];
            cnt++;
        end
        while (cnt < n && nucleus * 65536 < 64'(cur_topp) * total);
        target = (96'(draw) * 96'(nucleus)) >> 32;
        cum = 0;
        for (int i = 0; i < cnt; i++)
        begin
            cum += wts[order[i]];
            if (target <= 96'(cum))
            begin
                p.token = 12'(order[i]);
                return p;
            end
        end
        p.token = 12'(order[cnt-1]);
        return p;
    endfunction

    task automatic reg_write(input logic reg_id, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (reg_id == REG_TEMP)
            cur_temp = value[15:0];
        else
            cur_topp = value[16:0];
    endtask

    task automatic settle_and_config(input logic [15:0] t, input logic [16:0] tp);
        s_tvalid <= 1'b0;
        while (picks_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        reg_write(REG_TEMP, 32'(t));
        reg_write(REG_TOPP, 32'(tp));
    endtask

    // returns after the beat is accepted; result queued from typed value or predictor
    task automatic send_beat(input logic [15:0] logit, input logic last, input logic [31:0] draw,
                             input logic typed, input pick_t typed_pick);
        pick_t p;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {draw, logit};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (vec_logits.size() < VOCAB)
        begin
            vec_logits.insert(vec_logits.size(), logit);
            if ($signed(logit) > vec_max)
                vec_max = logit;
        end
        else
            vec_overflow = 1'b1;
        if (last)
        begin
            p = sample_token(draw);
            picks_due.insert(picks_due.size(), typed ? typed_pick : p);
            vec_logits.delete();
            vec_max = -16'sd32768;
            vec_overflow = 1'b0;
        end
    endtask

    function automatic logic [15:0] rand_logit(input logic [15:0] base);
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return base + 16'($urandom_range(255));
            default: return base + 16'($urandom_range(4095)) - 16'd2048;
        endcase
    endfunction

    function automatic logic [15:0] rand_temp();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_topp();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd1;
            2: return 17'h1FFFF;
            3: return 17'h10000 + 17'($urandom_range(65535));
            4, 5: return 17'h10000;
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_phase(input int items);
        int sent;
        int n;
        logic [15:0] base;
        sent = 0;
        settle_and_config(rand_temp(), rand_topp());
        while (sent < items)
        begin
            if ($urandom_range(5) == 0)
                settle_and_config(rand_temp(), rand_topp());
            n = ($urandom_range(39) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 12);
            base = 16'($urandom);
            for (int i = 0; i < n; i++)
                send_beat(rand_logit(base), i == n - 1, $urandom, 1'b0, '0);
            sent += n;
        end
    endtask

    function automatic void add_row(input logic [15:0] lg, input logic last, input logic [31:0] dr,
                                    input logic [15:0] t, input logic [16:0] tp,
                                    input logic typed = 1'b0, input pick_t pk = '0);
        row_t r;
        r.logit = lg;
        r.last  = last;
        r.draw  = dr;
        r.temp  = t;
        r.topp  = tp;
        r.typed = typed;
        r.pick  = pk;
        rows.insert(rows.size(), r);
    endfunction

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (picks_due.size() == 0)
            begin
                $display("%0t: unexpected result token %0d status %0d", $time,
                         m_tdata[11:0], m_tuser);
                errors++;
            end
            else
            begin
                if (m_tdata[11:0] !== picks_due[0].token)
                begin
                    $display("%0t: token_index expected %0d actual %0d", $time,
                             picks_due[0].token, m_tdata[11:0]);
                    errors++;
                end
                if (m_tuser !== picks_due[0].status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             picks_due[0].status, m_tuser);
                    errors++;
                end
                void'(picks_due.pop_front());
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] t_now;
        logic [16:0] tp_now;
        logic        vec_start;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rst_n    = 1'b0;
        errors   = 0;
        send_idle = 37;
        recv_idle = 47;
        cur_temp = TEMP_RESET;
        cur_topp = TOPP_RESET;
        vec_max  = -16'sd32768;
        vec_overflow = 1'b0;
        roots[0] = Q30 / 2;
        roots[1] = int_sqrt(64'd1 << 59);
        for (int k = 1; k < 16; k++)
            roots[k+1] = int_sqrt(roots[k] << 30);

        // reset-default config first, then extremes and the special cases
        add_row(16'h0000, 1, 32'h0, 16'd256, 17'h10000, 1, '{12'd0, STAT_OK});
        add_row(16'h8000, 0, 32'h0, 16'd0, 17'h10000);
        add_row(16'h7FFF, 0, 32'h0, 16'd0, 17'h10000);
        add_row(16'h7FFF, 1, 32'h0, 16'd0, 17'h10000, 1, '{12'd1, STAT_OK});
        add_row(16'h8000, 1, 32'hFFFFFFFF, 16'd0, 17'h10000, 1, '{12'd0, STAT_OK});
        add_row(16'h0003, 0, 32'h0, 16'd0, 17'h0);
        add_row(16'h0007, 1, 32'h0, 16'd0, 17'h0, 1, '{12'd1, STAT_OK});
        add_row(16'h0005, 1, 32'h1234, 16'd256, 17'h0, 1, '{12'd0, STAT_BAD_TOPP});
        add_row(16'h0001, 1, 32'h0, 16'd256, 17'h1FFFF, 1, '{12'd0, STAT_BAD_TOPP});
        add_row(16'h0064, 0, 32'h0, 16'hFFFF, 17'd1);
        add_row(16'hFF9C, 0, 32'h0, 16'hFFFF, 17'd1);
        add_row(16'h0000, 1, 32'hFFFFFFFF, 16'hFFFF, 17'd1);
        add_row(16'h000A, 0, 32'h0, 16'd1, 17'h10000);
        add_row(16'h000A, 0, 32'h0, 16'd1, 17'h10000);
        add_row(16'h8000, 1, 32'h0, 16'd1, 17'h10000);
        add_row(16'h0100, 0, 32'h0, 16'd256, 17'h08000);
        add_row(16'h0000, 0, 32'h0, 16'd256, 17'h08000);
        add_row(16'hFF00, 0, 32'h0, 16'd256, 17'h08000);
        add_row(16'h0200, 1, 32'h80000000, 16'd256, 17'h08000);
        add_row(16'h0000, 0, 32'h0, 16'd256, 17'h10000);
        add_row(16'h0000, 0, 32'h0, 16'd256, 17'h10000);
        add_row(16'h0000, 1, 32'hAAAAAAAA, 16'd256, 17'h10000);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        vec_start = 1'b1;
        t_now  = TEMP_RESET;
        tp_now = TOPP_RESET;
        foreach (rows[i])
        begin
            if (vec_start && (rows[i].temp != t_now || rows[i].topp != tp_now))
            begin
                settle_and_config(rows[i].temp, rows[i].topp);
                t_now  = rows[i].temp;
                tp_now = rows[i].topp;
            end
            send_beat(rows[i].logit, rows[i].last, rows[i].draw, rows[i].typed, rows[i].pick);
            vec_start = rows[i].last;
        end

        random_phase(550);
        send_idle = 47;
        recv_idle = 37;
        random_phase(550);
        send_idle = 0;
        recv_idle = 0;
        random_phase(550);

        // capacity overflow: one beat past the store, then a dropped last beat
        settle_and_config(16'd256, 17'h10000);
        for (int i = 0; i <= VOCAB; i++)
            send_beat(16'($urandom), 1'b0, 32'h0, 1'b0, '0);
        send_beat(16'h0000, 1'b1, $urandom, 1'b1, '{12'd0, STAT_OVERFLOW});
        send_beat(16'h0010, 1'b1, $urandom, 1'b0, '0);
        s_tvalid <= 1'b0;

        while (picks_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tps_pkg.sv
hw/rtl/tps_weight.sv
hw/rtl/top_p_token_sampler.sv
test/top_p_token_sampler_tb.sv
